FILE: sv/text_line_fold_top_defines.svh
// Assertion macros shared by the line folder modules.
`ifndef TEXT_LINE_FOLD_TOP_DEFINES_SVH
`define TEXT_LINE_FOLD_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TLF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define TLF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/tlf_pkg.sv
// Shared types and constants of the line folder.
`default_nettype none

package tlf_pkg;

  localparam int LEN_W  = 6;
  localparam int CHAR_W = 8;

  localparam logic [LEN_W-1:0]  ResetWidth = 6'd12;
  localparam logic [CHAR_W-1:0] CharSpace  = 8'd32;
  localparam logic [CHAR_W-1:0] CharTab    = 8'd9;
  localparam logic [CHAR_W-1:0] CharNl     = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic write;
    logic load_flush;
    logic emit_mem;
    logic emit_nl;
    logic in_flush;
  } tlf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fold_now;
    logic flush_now;
    logic pend_wr;
    logic flush_pend;
    logic rem_one;
    logic out_free;
  } tlf_sts_t;

endpackage

`default_nettype wire

FILE: sv/tlf_datapath.sv
// Line buffer, fold decision, read pointer and output register of the line folder.
`default_nettype none
`include "text_line_fold_top_defines.svh"

module tlf_datapath import tlf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 62
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LEN_W-1:0]  cfg_wdata_i,
  input  wire logic [CHAR_W-1:0] in_char_i,
  input  wire logic              in_last_i,
  input  wire tlf_cmd_t          cmd_i,
  output tlf_sts_t               sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   run_last_o,
  output logic                   text_end_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WIDTH);
  localparam logic [LEN_W:0]   MaxSum = (LEN_W+1)'(MAX_WIDTH);

  // Adds an offset to a circular buffer address.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [LEN_W-1:0] ofs);
    logic [LEN_W:0] sum;
    sum = (LEN_W+1)'(base) + {1'b0, ofs};
    if (sum >= MaxSum) begin
      sum = sum - MaxSum;
    end
    return sum[AW-1:0];
  endfunction

  // Line state.
  logic [LEN_W-1:0] width_q;
  logic [AW-1:0]    head_q, head_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] brk_pos_q, brk_pos_d;
  logic             brk_vld_q, brk_vld_d;
  logic             prev_nb_q, prev_nb_d;
  logic             skip_q, skip_d;
  logic [LEN_W-1:0] resume_q, resume_d;

  // Item and emission state.
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic [AW-1:0]     wr_addr_q;
  logic              pend_wr_q;
  logic              flush_pend_q;
  logic [AW-1:0]     flush_ptr_q;
  logic [LEN_W-1:0]  flush_len_q;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [LEN_W-1:0]  rem_q, rem_d;

  // Line memory.
  logic [CHAR_W-1:0] mem [MAX_WIDTH];
  logic [CHAR_W-1:0] rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q;
  logic              run_last_q;
  logic              text_end_q;
  logic              out_free;

  // Fold decision signals.
  logic             blank, drop, fold, fold_a, fold_b, fold_c;
  logic [LEN_W-1:0] wc, rest, fold_len;
  logic [LEN_W-1:0] cnt1, bp1, cnt2, bp2, res2;
  logic [AW-1:0]    head1, tail;
  logic             prev1, bv1, skip1, prev2, bv2;
  logic             app, wr_ok;

  // Clamp the configured width to the buffer depth; a width of 0 acts as 1.
  always_comb begin
    if (width_q == '0) begin
      wc = LEN_W'(1);
    end else if (width_q > MaxLen) begin
      wc = MaxLen;
    end else begin
      wc = width_q;
    end
  end

  // Classify the incoming byte and choose the kind of fold.
  assign blank  = (in_char_i == CharSpace) || (in_char_i == CharTab);
  assign drop   = skip_q && blank;
  assign fold   = !drop && (count_q >= wc);
  assign fold_a = fold && blank && prev_nb_q;
  assign fold_b = fold && !fold_a && brk_vld_q && (brk_pos_q < count_q);
  assign fold_c = fold && !fold_a && !fold_b;
  assign rest   = count_q - resume_q;

  // Line state after the fold.
  always_comb begin
    cnt1     = count_q;
    head1    = head_q;
    prev1    = prev_nb_q;
    bv1      = brk_vld_q;
    bp1      = brk_pos_q;
    fold_len = count_q;
    skip1    = 1'b0;
    if (fold_a || fold_c) begin
      cnt1  = '0;
      head1 = wrap_add(head_q, count_q);
      prev1 = 1'b0;
      bv1   = 1'b0;
      bp1   = '0;
      skip1 = fold_a;
    end else if (fold_b) begin
      cnt1     = rest;
      head1    = wrap_add(head_q, resume_q);
      prev1    = (rest != '0);
      bv1      = 1'b0;
      bp1      = '0;
      fold_len = brk_pos_q;
      skip1    = (rest == '0);
    end
  end

  // Line state after appending the incoming byte.
  assign app   = !drop && !fold_a && !(skip1 && blank);
  assign wr_ok = app && (cnt1 < MaxLen);
  assign tail  = wrap_add(head1, cnt1);

  always_comb begin
    cnt2  = cnt1;
    bv2   = bv1;
    bp2   = bp1;
    prev2 = prev1;
    res2  = resume_q;
    if (wr_ok) begin
      cnt2  = cnt1 + LEN_W'(1);
      prev2 = !blank;
      if (blank) begin
        res2 = cnt1 + LEN_W'(1);
      end
      if (blank && prev1) begin
        bv2 = 1'b1;
        bp2 = cnt1;
      end
    end
  end

  // Next line state; a last item clears the line after its flush is planned.
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    brk_pos_d = brk_pos_q;
    brk_vld_d = brk_vld_q;
    prev_nb_d = prev_nb_q;
    skip_d    = skip_q;
    resume_d  = resume_q;
    if (cmd_i.accept) begin
      head_d   = head1;
      resume_d = res2;
      if (in_last_i) begin
        count_d   = '0;
        brk_pos_d = '0;
        brk_vld_d = 1'b0;
        prev_nb_d = 1'b0;
        skip_d    = 1'b0;
      end else begin
        count_d   = cnt2;
        brk_pos_d = bp2;
        brk_vld_d = bv2;
        prev_nb_d = prev2;
        skip_d    = !app;
      end
    end
  end

  // Read pointer and remaining byte count of the current segment.
  always_comb begin
    ptr_d = ptr_q;
    rem_d = rem_q;
    if (cmd_i.accept) begin
      ptr_d = head_q;
      rem_d = fold_len;
    end else if (cmd_i.load_flush) begin
      ptr_d = flush_ptr_q;
      rem_d = flush_len_q;
    end else if (cmd_i.emit_mem) begin
      ptr_d = wrap_add(ptr_q, LEN_W'(1));
      rem_d = rem_q - LEN_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ResetWidth;
      head_q       <= '0;
      count_q      <= '0;
      brk_pos_q    <= '0;
      brk_vld_q    <= 1'b0;
      prev_nb_q    <= 1'b0;
      skip_q       <= 1'b0;
      resume_q     <= '0;
      pend_wr_q    <= 1'b0;
      flush_pend_q <= 1'b0;
      last_q       <= 1'b0;
      ptr_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      brk_pos_q   <= brk_pos_d;
      brk_vld_q   <= brk_vld_d;
      prev_nb_q   <= prev_nb_d;
      skip_q      <= skip_d;
      resume_q    <= resume_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        pend_wr_q    <= fold && wr_ok;
        flush_pend_q <= in_last_i && (cnt2 != '0);
        last_q       <= in_last_i;
      end
    end
  end

  // Item payload kept for the deferred write and the flush.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q      <= in_char_i;
      wr_addr_q   <= tail;
      flush_ptr_q <= head1;
      flush_len_q <= cnt2;
    end
  end

  // A byte is written at once unless a fold still has to read the old line.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = char_q;
    if (cmd_i.accept && wr_ok && !fold) begin
      mem_we    = 1'b1;
      mem_waddr = tail;
      mem_wdata = in_char_i;
    end else if (cmd_i.write) begin
      mem_we = 1'b1;
    end
  end

  // Line memory with a registered read one pointer step ahead.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[ptr_d];
  end

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_mem || cmd_i.emit_nl) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_mem) begin
      out_char_q <= rd_data_q;
      run_last_q <= cmd_i.in_flush && (rem_q == LEN_W'(1));
      text_end_q <= cmd_i.in_flush && (rem_q == LEN_W'(1));
    end else if (cmd_i.emit_nl) begin
      out_char_q <= CharNl;
      run_last_q <= !flush_pend_q;
      text_end_q <= !flush_pend_q && last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;
  assign text_end_o  = text_end_q;

  // Status to the controller.
  always_comb begin
    sts_o.fold_now   = fold;
    sts_o.flush_now  = in_last_i && (cnt2 != '0);
    sts_o.pend_wr    = pend_wr_q;
    sts_o.flush_pend = flush_pend_q;
    sts_o.rem_one    = (rem_q == LEN_W'(1));
    sts_o.out_free   = out_free;
  end

  // The line never outgrows the buffer.
  `TLF_ASSERT_ALWAYS(a_count_bound, count_q <= MaxLen, "line count exceeds buffer depth")
  // A fold candidate always lies inside the buffered line.
  `TLF_ASSERT_IMPL(a_brk_inside, brk_vld_q, brk_pos_q < count_q, "fold point outside line")
  // Bytes are read from the buffer only while the segment has bytes left.
  `TLF_ASSERT_IMPL(a_emit_rem, cmd_i.emit_mem, rem_q != '0, "buffer read past segment end")

endmodule

`default_nettype wire

FILE: sv/tlf_ctrl.sv
// Sequencing state machine of the line folder.
`default_nettype none
`include "text_line_fold_top_defines.svh"

module tlf_ctrl import tlf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tlf_sts_t sts_i,
  output tlf_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FOLD  = 3'd1;
  localparam logic [2:0] ST_NL    = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] cmd_act;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.fold_now) begin
            state_d = ST_FOLD;
          end else if (sts_i.flush_now) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_FOLD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_mem = 1'b1;
          if (sts_i.rem_one) begin
            state_d = ST_NL;
          end
        end
      end
      ST_NL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_nl = 1'b1;
          if (sts_i.pend_wr) begin
            state_d = ST_WR;
          end else if (sts_i.flush_pend) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WR: begin
        cmd_o.write = 1'b1;
        state_d     = sts_i.flush_pend ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load_flush = 1'b1;
        state_d          = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.in_flush = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit_mem = 1'b1;
          if (sts_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Datapath actions requested in this cycle.
  assign cmd_act = {cmd_o.accept, cmd_o.write, cmd_o.load_flush, cmd_o.emit_mem, cmd_o.emit_nl};

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one datapath action per cycle.
  `TLF_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_act), "conflicting datapath commands")
  // Nothing is loaded into a full, stalled output register.
  `TLF_ASSERT_IMPL(a_emit_free, cmd_o.emit_mem || cmd_o.emit_nl, sts_i.out_free, "output overwritten while stalled")

endmodule

`default_nettype wire

FILE: sv/text_line_fold_top.sv
// Top level of the word-wrapping line folder.
`default_nettype none

// Folds a byte stream into lines of at most line_width bytes (0 acts as 1, values above
// MAX_WIDTH act as MAX_WIDTH). A line breaks at the first blank of its last blank run that
// follows a non-blank byte, and that run is dropped; without such a blank the line breaks
// hard at its full length. Each break emits the line bytes and a newline. A byte with
// in_last set flushes the line; run_last marks the last output item caused by an input
// item and text_end the last item of the text. A byte that does not fold or flush is
// taken without a stall. An item that folds or flushes stalls the input while the
// line bytes go out, one per cycle while the output is free, then the newline of a fold,
// then a store of the incoming byte when a fold keeps it and a restart of the buffer read
// before a flush, as the line memory has a single read port with a registered output. The
// line buffer needs no clearing after reset.
module text_line_fold_top import tlf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 62
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LEN_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CHAR_W-1:0] in_char_i,
  input  wire logic              in_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   run_last_o,
  output logic                   text_end_o
);

  tlf_cmd_t cmd;
  tlf_sts_t sts;

  // Controller.
  tlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  tlf_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

endmodule

`default_nettype wire
